>>> rtl/genotype_line_decode_qc_filter_defines.svh
// Assertion macros for the genotype line decoder RTL.
// Included by gldqc_accum, the only module that carries concurrent checks; no other dependencies.
`ifndef GENOTYPE_LINE_DECODE_QC_FILTER_DEFINES_SVH
`define GENOTYPE_LINE_DECODE_QC_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GLDQC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("genotype line decoder check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GLDQC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("genotype line decoder check failed");

`endif

>>> rtl/gldqc_pkg.sv
// Shared types, constants and the genotype decode function of the line decoder.
// No dependencies; imported by every module of the block.
package gldqc_pkg;

  // Field widths.
  localparam int IND_W      = 21;
  localparam int MAC_W      = 22;
  localparam int MAF_W      = 16;
  localparam int MISS_W     = 15;
  localparam int POS_W      = IND_W - 2;
  localparam int ORD_W      = 16;
  localparam int CFG_DATA_W = 22;
  localparam int CFG_ADDR_W = 2;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 120;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_INDIVIDUAL_COUNT = 2'd0,
    REG_MIN_ALLELE_COUNT = 2'd1,
    REG_MIN_ALLELE_FREQ  = 2'd2,
    REG_MAX_MISSING_RATE = 2'd3
  } cfg_reg_t;

  // Reset values and threshold ceilings.
  localparam logic [IND_W-1:0]  RST_INDIVIDUAL_COUNT = 21'd1;
  localparam logic [MAC_W-1:0]  RST_MIN_ALLELE_COUNT = 22'd1;
  localparam logic [MAF_W-1:0]  RST_MIN_ALLELE_FREQ  = 16'd0;
  localparam logic [MISS_W-1:0] RST_MAX_MISSING_RATE = 15'd3277;
  localparam logic [MAF_W-1:0]  MAF_THR_MAX          = 16'd32768;
  localparam logic [MISS_W-1:0] MISS_THR_MAX         = 15'd16384;

  // Raw two-bit codes as stored in the file.
  localparam logic [1:0] RAW_HOM_REF = 2'b00;
  localparam logic [1:0] RAW_MISSING = 2'b01;
  localparam logic [1:0] RAW_HET     = 2'b10;
  localparam logic [1:0] RAW_HOM_ALT = 2'b11;

  // Decoded genotype classes.
  typedef enum logic [1:0] {
    GENO_HOM_REF = 2'd0,
    GENO_HET     = 2'd1,
    GENO_HOM_ALT = 2'd2,
    GENO_MISSING = 2'd3
  } geno_t;

  typedef struct packed {
    logic [IND_W-1:0]  individual_count;
    logic [MAC_W-1:0]  min_allele_count;
    logic [MAF_W-1:0]  min_allele_freq_q16;
    logic [MISS_W-1:0] max_missing_rate_q16;
  } cfg_t;

  // One decoded byte plus the running class counts after it.
  typedef struct packed {
    logic [3:0][1:0]  genotype;
    logic [2:0]       real_genotypes;
    logic             line_done;
    logic [IND_W-1:0] het_total;
    logic [IND_W-1:0] hom_alt_total;
    logic [IND_W-1:0] missing_total;
    logic [ORD_W-1:0] line_ordinal;
  } tally_t;

  // Finished result beat.
  typedef struct packed {
    tally_t           tally;
    logic [MAC_W-1:0] minor_allele_total;
    logic             line_included;
  } result_t;

  function automatic geno_t decode_code(input logic [1:0] raw);
    geno_t g;
    unique case (raw)
      RAW_HOM_REF: g = GENO_HOM_REF;
      RAW_MISSING: g = GENO_MISSING;
      RAW_HET:     g = GENO_HET;
      RAW_HOM_ALT: g = GENO_HOM_ALT;
      default:     g = GENO_MISSING;
    endcase
    return g;
  endfunction

endpackage

>>> rtl/gldqc_accum.sv
// Decode and count stage: decodes four genotypes per byte and keeps the line counts.
// Depends on gldqc_pkg and the assertion macro header.
`include "genotype_line_decode_qc_filter_defines.svh"

module gldqc_accum #(
  parameter int LINE_COUNTER_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [gldqc_pkg::IND_W-1:0]          n_eff,
  input  logic                                 line_clear,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [gldqc_pkg::IN_DATA_W-1:0]      in_byte,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output gldqc_pkg::tally_t                    out_tally
);
  import gldqc_pkg::*;

  logic                         v_r;
  logic [POS_W-1:0]             pos_r, pos_nxt;
  logic [IND_W-1:0]             het_r, het_nxt;
  logic [IND_W-1:0]             hom_r, hom_nxt;
  logic [IND_W-1:0]             miss_r, miss_nxt;
  logic [LINE_COUNTER_BITS-1:0] line_cnt_r, line_cnt_nxt;
  tally_t                       tally_r, tally_nxt;

  logic                         accept;
  logic                         done;
  logic [IND_W-1:0]             n_m1;
  logic [POS_W-1:0]             last_pos;
  logic [IND_W-1:0]             left;
  logic [2:0]                   real_cnt;
  logic [2:0]                   inc_het, inc_hom, inc_miss;
  logic [IND_W-1:0]             het_sum, hom_sum, miss_sum;
  geno_t                        geno [4];

  assign in_ready  = !v_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = v_r;
  assign out_tally = tally_r;

  // Position of this byte in the line and how many of its codes are real.
  assign n_m1     = n_eff - IND_W'(1);
  assign last_pos = n_m1[IND_W-1:2];
  assign done     = (pos_r >= last_pos);
  assign left     = n_eff - {pos_r, 2'b00};
  assign real_cnt = (left >= IND_W'(4)) ? 3'd4 : left[2:0];

  // Decode the four codes and count the real ones per class.
  always_comb begin
    inc_het  = 3'd0;
    inc_hom  = 3'd0;
    inc_miss = 3'd0;
    for (int k = 0; k < 4; k++) begin
      geno[k] = decode_code(in_byte[2*k +: 2]);
      if (3'(k) < real_cnt) begin
        case (geno[k])
          GENO_HET:     inc_het  = inc_het + 3'd1;
          GENO_HOM_ALT: inc_hom  = inc_hom + 3'd1;
          GENO_MISSING: inc_miss = inc_miss + 3'd1;
          default:      ;
        endcase
      end
    end
  end

  assign het_sum  = het_r + IND_W'(inc_het);
  assign hom_sum  = hom_r + IND_W'(inc_hom);
  assign miss_sum = miss_r + IND_W'(inc_miss);

  // Beat handed to the filter stage.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      tally_nxt.genotype[k] = geno[k];
    end
    tally_nxt.real_genotypes = real_cnt;
    tally_nxt.line_done      = done;
    tally_nxt.het_total      = het_sum;
    tally_nxt.hom_alt_total  = hom_sum;
    tally_nxt.missing_total  = miss_sum;
    tally_nxt.line_ordinal   = ORD_W'(line_cnt_r);
  end

  // Line state update: a new individual count drops the partial line.
  always_comb begin
    pos_nxt      = pos_r;
    het_nxt      = het_r;
    hom_nxt      = hom_r;
    miss_nxt     = miss_r;
    line_cnt_nxt = line_cnt_r;
    if (line_clear) begin
      pos_nxt  = '0;
      het_nxt  = '0;
      hom_nxt  = '0;
      miss_nxt = '0;
    end else if (accept) begin
      if (done) begin
        pos_nxt      = '0;
        het_nxt      = '0;
        hom_nxt      = '0;
        miss_nxt     = '0;
        line_cnt_nxt = line_cnt_r + LINE_COUNTER_BITS'(1);
      end else begin
        pos_nxt  = pos_r + POS_W'(1);
        het_nxt  = het_sum;
        hom_nxt  = hom_sum;
        miss_nxt = miss_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r        <= 1'b0;
      pos_r      <= '0;
      het_r      <= '0;
      hom_r      <= '0;
      miss_r     <= '0;
      line_cnt_r <= '0;
    end else begin
      if (in_ready) begin
        v_r <= in_valid;
      end
      pos_r      <= pos_nxt;
      het_r      <= het_nxt;
      hom_r      <= hom_nxt;
      miss_r     <= miss_nxt;
      line_cnt_r <= line_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tally_r <= tally_nxt;
    end
  end

  // Every byte before the last one of a line carries four real individuals.
  `GLDQC_ASSERT_IMP(a_inner_byte_full, clk, rst_n, accept && !done, real_cnt == 3'd4)
  // The byte position never runs past the end of the configured line.
  `GLDQC_ASSERT_IMP(a_pos_in_line, clk, rst_n, 1'b1, pos_r <= last_pos)
  // Closing a line restarts the position at the first byte.
  `GLDQC_ASSERT_NXT(a_line_restart, clk, rst_n, accept && done, pos_r == '0)

endmodule

>>> rtl/gldqc_qc.sv
// Quality filter stages: minor allele count folding and the three threshold tests.
// Depends on gldqc_pkg.
module gldqc_qc (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gldqc_pkg::cfg_t              cfg,
  input  logic [gldqc_pkg::IND_W-1:0]  n_eff,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  gldqc_pkg::tally_t            in_tally,
  output logic                         out_valid,
  input  logic                         out_ready,
  output gldqc_pkg::result_t           out_result
);
  import gldqc_pkg::*;

  typedef struct packed {
    tally_t           tally;
    logic [IND_W-1:0] nobs;
    logic [MAC_W-1:0] mac;
    logic             miss_ok;
  } qc_mid_t;

  logic             b_v_r;
  qc_mid_t          b_r, b_nxt;
  logic             c_v_r;
  result_t          res_r, res_nxt;
  logic             b_ready, c_ready;

  logic [MAC_W-1:0]          mac_thr;
  logic [MAF_W-1:0]          maf_thr;
  logic [MISS_W-1:0]         miss_thr;
  logic [MAC_W-1:0]          mac_raw;
  logic [MISS_W+IND_W-1:0]   miss_prod;
  logic [MAF_W+IND_W-1:0]    maf_prod;
  logic                      maf_ok;
  logic                      inc;

  assign c_ready    = !c_v_r || out_ready;
  assign b_ready    = !b_v_r || c_ready;
  assign in_ready   = b_ready;
  assign out_valid  = c_v_r;
  assign out_result = res_r;

  // Thresholds with out-of-range settings pulled to their limits.
  assign mac_thr  = (cfg.min_allele_count == '0) ? MAC_W'(1) : cfg.min_allele_count;
  assign maf_thr  = (cfg.min_allele_freq_q16 > MAF_THR_MAX) ? MAF_THR_MAX
                                                            : cfg.min_allele_freq_q16;
  assign miss_thr = (cfg.max_missing_rate_q16 > MISS_THR_MAX) ? MISS_THR_MAX
                                                              : cfg.max_missing_rate_q16;

  // First stage: observed count, folded allele count and the missing-rate test.
  always_comb begin
    b_nxt.tally = in_tally;
    b_nxt.nobs  = n_eff - in_tally.missing_total;
    mac_raw     = MAC_W'(in_tally.het_total) + {in_tally.hom_alt_total, 1'b0};
    if (mac_raw > MAC_W'(b_nxt.nobs)) begin
      b_nxt.mac = {b_nxt.nobs, 1'b0} - mac_raw;
    end else begin
      b_nxt.mac = mac_raw;
    end
    miss_prod     = (MISS_W+IND_W)'(miss_thr) * (MISS_W+IND_W)'(n_eff);
    b_nxt.miss_ok = ({in_tally.missing_total, 16'b0} <= (IND_W+16)'(miss_prod));
  end

  // Second stage: allele count and frequency tests, summary gated by line end.
  always_comb begin
    maf_prod = (MAF_W+IND_W)'(maf_thr) * (MAF_W+IND_W)'(b_r.nobs);
    maf_ok   = ({b_r.mac, 16'b0} >= (MAC_W+16)'({maf_prod, 1'b0}));
    inc      = b_r.miss_ok && (b_r.nobs != '0) && (b_r.mac >= mac_thr) && maf_ok;

    res_nxt.tally              = b_r.tally;
    res_nxt.minor_allele_total = b_r.mac;
    res_nxt.line_included      = inc;
    if (!b_r.tally.line_done) begin
      res_nxt.tally.het_total     = '0;
      res_nxt.tally.hom_alt_total = '0;
      res_nxt.tally.missing_total = '0;
      res_nxt.minor_allele_total  = '0;
      res_nxt.line_included       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      if (b_ready) begin
        b_v_r <= in_valid;
      end
      if (c_ready) begin
        c_v_r <= b_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && b_ready) begin
      b_r <= b_nxt;
    end
    if (b_v_r && c_ready) begin
      res_r <= res_nxt;
    end
  end

endmodule

>>> rtl/genotype_line_decode_qc_filter.sv
// Top level of the genotype line decoder with per-line quality filter.
// Depends on gldqc_pkg, gldqc_accum and gldqc_qc.
//
// One packed genotype byte enters per beat and one result beat leaves per input
// beat, in order. The block takes a new byte every cycle unless out_tready stalls
// it; each byte passes through decode and count, fold and missing-rate test, and
// frequency test and output register, and the output register frees itself within
// the same cycle that out_tready takes the waiting beat. The last byte of a line
// is marked by out_tlast and carries the line summary; on other beats the summary
// fields read zero. Writing the individual count drops any partial line; the user
// writes configuration while no beats are in flight; the block does not check it.
module genotype_line_decode_qc_filter #(
  parameter int MAX_INDIVIDUALS   = 1048576,
  parameter int LINE_COUNTER_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input stream.
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [gldqc_pkg::IN_DATA_W-1:0]       in_tdata,   // [7:0] packed_byte
  // Result stream.
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [1:0] genotype_0, [3:2] genotype_1, [5:4] genotype_2, [7:6] genotype_3,
  // [10:8] real_genotypes, [31:11] het_total, [52:32] hom_alt_total,
  // [73:53] missing_total, [95:74] minor_allele_total, [96] line_included,
  // [112:97] line_ordinal, [119:113] zero
  output logic [gldqc_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                  out_tlast,  // line_done
  // Configuration write port.
  input  logic                                  cfg_we,
  input  logic [gldqc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [gldqc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import gldqc_pkg::*;

  localparam logic [31:0] MAX_IND = 32'(MAX_INDIVIDUALS);

  cfg_t             cfg_r;
  logic [IND_W-1:0] n_eff;
  logic             line_clear;
  logic             mid_valid, mid_ready;
  tally_t           mid_tally;
  result_t          result;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.individual_count     <= RST_INDIVIDUAL_COUNT;
      cfg_r.min_allele_count     <= RST_MIN_ALLELE_COUNT;
      cfg_r.min_allele_freq_q16  <= RST_MIN_ALLELE_FREQ;
      cfg_r.max_missing_rate_q16 <= RST_MAX_MISSING_RATE;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_INDIVIDUAL_COUNT: cfg_r.individual_count     <= cfg_wdata[IND_W-1:0];
        REG_MIN_ALLELE_COUNT: cfg_r.min_allele_count     <= cfg_wdata[MAC_W-1:0];
        REG_MIN_ALLELE_FREQ:  cfg_r.min_allele_freq_q16  <= cfg_wdata[MAF_W-1:0];
        REG_MAX_MISSING_RATE: cfg_r.max_missing_rate_q16 <= cfg_wdata[MISS_W-1:0];
        default: ;
      endcase
    end
  end

  assign line_clear = cfg_we && (cfg_reg_t'(cfg_addr) == REG_INDIVIDUAL_COUNT);

  // Effective individual count: zero acts as one, large values are capped.
  always_comb begin
    n_eff = cfg_r.individual_count;
    if (n_eff == '0) begin
      n_eff = IND_W'(1);
    end else if (32'(cfg_r.individual_count) > MAX_IND) begin
      n_eff = MAX_IND[IND_W-1:0];
    end
  end

  gldqc_accum #(
    .LINE_COUNTER_BITS (LINE_COUNTER_BITS)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .n_eff      (n_eff),
    .line_clear (line_clear),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata),
    .out_valid  (mid_valid),
    .out_ready  (mid_ready),
    .out_tally  (mid_tally)
  );

  gldqc_qc u_qc (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .n_eff      (n_eff),
    .in_valid   (mid_valid),
    .in_ready   (mid_ready),
    .in_tally   (mid_tally),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (result)
  );

  // Result beat packing, first field in the lowest bits.
  assign out_tdata = {7'b0,
                      result.tally.line_ordinal,
                      result.line_included,
                      result.minor_allele_total,
                      result.tally.missing_total,
                      result.tally.hom_alt_total,
                      result.tally.het_total,
                      result.tally.real_genotypes,
                      result.tally.genotype};
  assign out_tlast = result.tally.line_done;

endmodule
